// ===== hdl/atan2_polynomial_unit_defines.svh =====
// assertion macros used by the rtl top level
`ifndef ATAN2_POLYNOMIAL_UNIT_DEFINES_SVH
`define ATAN2_POLYNOMIAL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define AP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define AP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define AP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/atan2pu_pkg.sv =====
`default_nettype none
package atan2pu_pkg;

    localparam int IN_WIDTH        = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;
    localparam int QUO_WIDTH       = 17;
    localparam int DIV_STAGES      = 17;
    localparam int H_STAGES        = 5;
    localparam int S_WIDTH         = 24;
    localparam int A_WIDTH         = 40;
    localparam int OUT_SHIFT       = 32 - ANGLE_FRAC_BITS;

    // q2.16 coefficients, degree 0 up to degree 5
    localparam logic signed [S_WIDTH-1:0] COEF [6] = '{
        -24'sd4, 24'sd65513, 24'sd1198, -24'sd29137, 24'sd17248, -24'sd3347
    };

    localparam logic signed [A_WIDTH-1:0] PI_Q32      = 40'sd13493037705;
    localparam logic signed [A_WIDTH-1:0] HALF_PI_Q32 = 40'sd6746518852;
    localparam logic [A_WIDTH-1:0] ANGLE_LIM =
        (40'd13493037705 + (40'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;

    // octant side information carried down the pipe
    typedef struct packed {
        logic swap;
        logic xneg;
        logic yneg;
        logic zero;
    } t_oct;

endpackage
`default_nettype wire

// ===== hdl/atan2pu_div.sv =====
`default_nettype none
module atan2pu_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_vld,
    input  wire atan2pu_pkg::t_oct                 i_oct,
    input  wire logic [atan2pu_pkg::IN_WIDTH-1:0]  i_lo,
    input  wire logic [atan2pu_pkg::IN_WIDTH-1:0]  i_hi,
    output logic                                   o_vld,
    output atan2pu_pkg::t_oct                      o_oct,
    output logic [atan2pu_pkg::QUO_WIDTH-1:0]      o_quo
);
    import atan2pu_pkg::*;

    logic                 r_vld [DIV_STAGES];
    t_oct                 r_oct [DIV_STAGES];
    logic [IN_WIDTH-1:0]  r_rem [DIV_STAGES];
    logic [IN_WIDTH-1:0]  r_dvs [DIV_STAGES];
    logic [QUO_WIDTH-1:0] r_quo [DIV_STAGES];

    logic [IN_WIDTH-1:0]  n_rem [DIV_STAGES];
    logic [QUO_WIDTH-1:0] n_quo [DIV_STAGES];

    // one quotient bit per stage, restoring compare and subtract
    always_comb begin
        logic [IN_WIDTH:0] t;
        logic [IN_WIDTH:0] d;
        logic              ge;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                t = {1'b0, i_lo};
                d = {1'b0, i_hi};
            end else begin
                t = {r_rem[k-1], 1'b0};
                d = {1'b0, r_dvs[k-1]};
            end
            ge = (t >= d);
            n_rem[k] = ge ? IN_WIDTH'(t - d) : IN_WIDTH'(t);
            if (k == 0) begin
                n_quo[k] = {{(QUO_WIDTH-1){1'b0}}, ge};
            end else begin
                n_quo[k] = {r_quo[k-1][QUO_WIDTH-2:0], ge};
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) r_vld[k] <= (k == 0) ? i_vld : r_vld[k-1];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_dvs[k] <= (k == 0) ? i_hi : r_dvs[k-1];
                r_oct[k] <= (k == 0) ? i_oct : r_oct[k-1];
            end
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_oct = r_oct[DIV_STAGES-1];
    assign o_quo = r_quo[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== hdl/atan2_polynomial_unit.sv =====
// channel | valid      | stall       | payload
// request | i_in_valid | o_in_stall  | i_y_value, i_x_value
// result  | o_out_valid| i_out_stall | o_angle
//
// pipeline: 1 magnitude stage, 17 divider stages (one quotient bit
// each), 5 horner stages (one multiply each), 2 octant/rounding stages.
// one request per cycle; the whole pipe advances unless a result is held.
// o_in_stall follows i_out_stall while the output register is full.
// reset clears the valid bits only.
`default_nettype none
`include "atan2_polynomial_unit_defines.svh"
module atan2_polynomial_unit (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_in_valid,
    output logic                                            o_in_stall,
    input  wire logic signed [atan2pu_pkg::IN_WIDTH-1:0]    i_y_value,
    input  wire logic signed [atan2pu_pkg::IN_WIDTH-1:0]    i_x_value,
    output logic                                            o_out_valid,
    input  wire logic                                       i_out_stall,
    output logic signed [atan2pu_pkg::ANGLE_WIDTH-1:0]      o_angle
);
    import atan2pu_pkg::*;

    logic en;
    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // magnitude and swap stage
    logic                r_m_vld;
    t_oct                r_m_oct;
    logic [IN_WIDTH-1:0] r_m_lo;
    logic [IN_WIDTH-1:0] r_m_hi;
    t_oct                n_m_oct;
    logic [IN_WIDTH-1:0] n_m_lo;
    logic [IN_WIDTH-1:0] n_m_hi;

    always_comb begin
        logic [IN_WIDTH-1:0] ym;
        logic [IN_WIDTH-1:0] xm;
        ym = i_y_value[IN_WIDTH-1] ? IN_WIDTH'(-i_y_value) : IN_WIDTH'(i_y_value);
        xm = i_x_value[IN_WIDTH-1] ? IN_WIDTH'(-i_x_value) : IN_WIDTH'(i_x_value);
        n_m_oct.swap = ym > xm;
        n_m_oct.xneg = i_x_value[IN_WIDTH-1];
        n_m_oct.yneg = i_y_value[IN_WIDTH-1];
        n_m_oct.zero = (ym == '0) && (xm == '0);
        n_m_lo = n_m_oct.swap ? xm : ym;
        n_m_hi = n_m_oct.swap ? ym : xm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_oct <= n_m_oct;
            r_m_lo  <= n_m_lo;
            r_m_hi  <= n_m_hi;
        end
    end

    // ratio divider
    logic                 d_vld;
    t_oct                 d_oct;
    logic [QUO_WIDTH-1:0] d_quo;

    atan2pu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_m_vld),
        .i_oct   (r_m_oct),
        .i_lo    (r_m_lo),
        .i_hi    (r_m_hi),
        .o_vld   (d_vld),
        .o_oct   (d_oct),
        .o_quo   (d_quo)
    );

    // horner stages
    logic                        r_h_vld [H_STAGES];
    t_oct                        r_h_oct [H_STAGES];
    logic [QUO_WIDTH-1:0]        r_h_g   [H_STAGES];
    logic signed [S_WIDTH-1:0]   r_h_s   [H_STAGES];
    logic signed [S_WIDTH-1:0]   n_h_s   [H_STAGES];

    always_comb begin
        logic signed [S_WIDTH-1:0]            s_in;
        logic [QUO_WIDTH-1:0]                 g_in;
        logic signed [S_WIDTH+QUO_WIDTH:0]    prod;
        logic [S_WIDTH+QUO_WIDTH:0]           mag;
        logic [S_WIDTH+QUO_WIDTH:0]           rnd;
        logic signed [S_WIDTH-1:0]            term;
        for (int h = 0; h < H_STAGES; h++) begin
            s_in = (h == 0) ? COEF[5] : r_h_s[h-1];
            g_in = (h == 0) ? d_quo : r_h_g[h-1];
            prod = (S_WIDTH+QUO_WIDTH+1)'(s_in)
                 * (S_WIDTH+QUO_WIDTH+1)'($signed({1'b0, g_in}));
            mag  = prod[S_WIDTH+QUO_WIDTH] ? (S_WIDTH+QUO_WIDTH+1)'(-prod)
                                           : (S_WIDTH+QUO_WIDTH+1)'(prod);
            rnd  = (mag + ((S_WIDTH+QUO_WIDTH+1)'(1) << 15)) >> 16;
            term = prod[S_WIDTH+QUO_WIDTH] ? -$signed(rnd[S_WIDTH-1:0])
                                           : $signed(rnd[S_WIDTH-1:0]);
            n_h_s[h] = term + COEF[4-h];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int h = 0; h < H_STAGES; h++) r_h_vld[h] <= 1'b0;
        end else if (en) begin
            for (int h = 0; h < H_STAGES; h++) r_h_vld[h] <= (h == 0) ? d_vld : r_h_vld[h-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int h = 0; h < H_STAGES; h++) begin
                r_h_s[h]   <= n_h_s[h];
                r_h_g[h]   <= (h == 0) ? d_quo : r_h_g[h-1];
                r_h_oct[h] <= (h == 0) ? d_oct : r_h_oct[h-1];
            end
        end
    end

    // octant fixes for swap and negative x
    logic                      r_f_vld;
    t_oct                      r_f_oct;
    logic signed [A_WIDTH-1:0] r_f_a;
    logic signed [A_WIDTH-1:0] n_f_a;

    always_comb begin
        logic signed [A_WIDTH-1:0] a;
        a = A_WIDTH'(r_h_s[H_STAGES-1]) <<< 16;
        if (r_h_oct[H_STAGES-1].swap) a = HALF_PI_Q32 - a;
        if (r_h_oct[H_STAGES-1].xneg) a = PI_Q32 - a;
        n_f_a = a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= r_h_vld[H_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_a   <= n_f_a;
            r_f_oct <= r_h_oct[H_STAGES-1];
        end
    end

    // sign, rounding and saturation
    logic                            r_o_vld;
    logic signed [ANGLE_WIDTH-1:0]   r_o_angle;
    logic signed [ANGLE_WIDTH-1:0]   n_o_angle;

    always_comb begin
        logic               neg;
        logic [A_WIDTH-1:0] mag;
        logic [A_WIDTH-1:0] rnd;
        neg = r_f_a[A_WIDTH-1] ^ r_f_oct.yneg;
        mag = r_f_a[A_WIDTH-1] ? A_WIDTH'(-r_f_a) : A_WIDTH'(r_f_a);
        rnd = (mag + (A_WIDTH'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (rnd > ANGLE_LIM) rnd = ANGLE_LIM;
        if (r_f_oct.zero) begin
            n_o_angle = '0;
        end else if (neg) begin
            n_o_angle = -$signed(rnd[ANGLE_WIDTH-1:0]);
        end else begin
            n_o_angle = $signed(rnd[ANGLE_WIDTH-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_angle <= n_o_angle;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_angle     = r_o_angle;

    // result stays within plus or minus pi
    logic angle_ok;
    assign angle_ok = (o_angle <= $signed(ANGLE_WIDTH'(ANGLE_LIM)))
                   && (o_angle >= -$signed(ANGLE_WIDTH'(ANGLE_LIM)));

    // checks
    `AP_ASSERT_IMPL(a_no_stall_when_free, i_clk, i_rst_n, !i_out_stall, !o_in_stall)
    `AP_ASSERT_NEXT(a_last_stage_moves, i_clk, i_rst_n, en && r_f_vld, o_out_valid)
    `AP_ASSERT_IMPL(a_angle_in_range, i_clk, i_rst_n, o_out_valid, angle_ok)

endmodule
`default_nettype wire

// ===== tb/sv/atan2_polynomial_unit_tb.sv =====
`default_nettype none
module atan2_polynomial_unit_tb;
    import atan2pu_pkg::*;

    // angle predictor and store of expected angles
    class angle_scoreboard;
        logic signed [ANGLE_WIDTH-1:0] pending_angles[$];
        int errors;
        int shown;

        function automatic longint round_off(longint v, int sh);
            longint mag;
            mag = (v < 0) ? -v : v;
            mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
            return (v < 0) ? -mag : mag;
        endfunction

        function automatic logic signed [ANGLE_WIDTH-1:0] predict_angle(
            logic signed [IN_WIDTH-1:0] y, logic signed [IN_WIDTH-1:0] x);
            longint ym;
            longint xm;
            longint lo;
            longint hi;
            longint g;
            longint s;
            longint a;
            longint lim;
            longint cf[6];
            bit swapped;
            cf = '{-4, 65513, 1198, -29137, 17248, -3347};
            ym = (y < 0) ? -longint'(y) : longint'(y);
            xm = (x < 0) ? -longint'(x) : longint'(x);
            if (ym == 0 && xm == 0) return '0;
            swapped = ym > xm;
            lo = swapped ? xm : ym;
            hi = swapped ? ym : xm;
            g = (lo <<< 16) / hi;
            s = cf[5];
            for (int k = 4; k >= 0; k--) s = round_off(s * g, 16) + cf[k];
            a = s * 65536;
            if (swapped) a = 64'sd6746518852 - a;
            if (x < 0) a = 64'sd13493037705 - a;
            if (y < 0) a = -a;
            a = round_off(a, 32 - ANGLE_FRAC_BITS);
            lim = round_off(64'sd13493037705, 32 - ANGLE_FRAC_BITS);
            if (a > lim) a = lim;
            if (a < -lim) a = -lim;
            return a[ANGLE_WIDTH-1:0];
        endfunction

        function void note_request(logic signed [IN_WIDTH-1:0] y,
                                   logic signed [IN_WIDTH-1:0] x);
            pending_angles.push_back(predict_angle(y, x));
        endfunction

        function void check_angle(logic signed [ANGLE_WIDTH-1:0] got);
            logic signed [ANGLE_WIDTH-1:0] want;
            if (pending_angles.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result angle %0d", got);
                end
                return;
            end
            want = pending_angles.pop_front();
            if (got !== want) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("angle mismatch: expected %0d actual %0d", want, got);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    logic signed [IN_WIDTH-1:0] i_y_value = '0;
    logic signed [IN_WIDTH-1:0] i_x_value = '0;
    logic o_in_stall;
    logic o_out_valid;
    logic signed [ANGLE_WIDTH-1:0] o_angle;

    int send_idle_pct;
    int recv_idle_pct;
    angle_scoreboard angle_sb = new();

    atan2_polynomial_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_y_value(i_y_value), .i_x_value(i_x_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_angle(o_angle)
    );

    always #5 i_clk = ~i_clk;

    // request and result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) angle_sb.note_request(i_y_value, i_x_value);
        if (i_rst_n && o_out_valid && !i_out_stall) angle_sb.check_angle(o_angle);
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // drive one request, holding it until taken
    task automatic send_request(logic signed [IN_WIDTH-1:0] y, logic signed [IN_WIDTH-1:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_y_value <= y;
        i_x_value <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        logic signed [IN_WIDTH-1:0] y;
        logic signed [IN_WIDTH-1:0] x;
        for (int n = 0; n < count; n++) begin
            y = IN_WIDTH'($urandom);
            x = IN_WIDTH'($urandom);
            case ($urandom_range(7))
                0: x = y;
                1: x = -y;
                2: y = IN_WIDTH'($urandom_range(3) - 2);
                3: x = IN_WIDTH'($urandom_range(3) - 2);
                default: ;
            endcase
            send_request(y, x);
        end
    endtask

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic signed [IN_WIDTH-1:0] corner[8];
        corner = '{0, 1, -1, 32767, -32768, 100, -100, 16384};
        send_idle_pct = 30;
        recv_idle_pct = 84;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners: zeros, equal magnitudes, most negative, axes
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++)
                send_request(corner[i], corner[j]);

        send_random(140);
        send_idle_pct = 84;
        recv_idle_pct = 30;
        send_random(140);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(170);
        i_in_valid <= 1'b0;

        // drain outstanding results
        while (angle_sb.pending_angles.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (angle_sb.errors == 0 && angle_sb.pending_angles.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/atan2pu_pkg.sv
hdl/atan2pu_div.sv
hdl/atan2_polynomial_unit.sv
tb/sv/atan2_polynomial_unit_tb.sv
